### rtl/ahfe_pkg.sv
// Shared constants, types and functions of the asynchronous HDLC frame encoder.
package ahfe_pkg;

	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 16;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
	localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
	localparam logic [BYTE_W-1:0] DC2_BYTE  = 8'h12;
	localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;
	localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8408;

	// One classified payload byte, handed from the front end to the back end.
	typedef struct packed {
		logic              open;
		logic [BYTE_W-1:0] data;
		logic              eof;
		logic [CRC_W-1:0]  fcs;
	} cmd_t;

	function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
		return (b == ESC_BYTE) || (b == FLAG_BYTE) || (b == XON_BYTE) ||
			(b == DC2_BYTE) || (b == XOFF_BYTE);
	endfunction

	// Reflected CRC-16 update over one byte, least significant bit first.
	function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] v;
		v = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

### rtl/ahfe_if.sv
// Valid/ready channel interfaces for payload bytes and line bytes.
interface ahfe_in_if;
	logic                        valid;
	logic                        ready;
	logic [ahfe_pkg::BYTE_W-1:0] data_byte;
	logic                        end_of_frame;

	modport source(output valid, output data_byte, output end_of_frame, input ready);
	modport sink(input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface ahfe_out_if;
	logic                        valid;
	logic                        ready;
	logic [ahfe_pkg::BYTE_W-1:0] line_byte;
	logic                        run_last;
	logic                        frame_closed;

	modport source(output valid, output line_byte, output run_last, output frame_closed,
		input ready);
	modport sink(input valid, input line_byte, input run_last, input frame_closed,
		output ready);
endinterface

### rtl/async_hdlc_frame_encoder.sv
// Top level of the asynchronous HDLC-like frame encoder.
// The encoder takes one unescaped payload byte per transaction on data_ch and sends
// the framed line stream, one byte per transaction, on line_ch. The first byte of a
// frame is preceded by the opening flag 0x7E; bytes 0x7D, 0x7E, 0x11, 0x12 and 0x13
// go out as 0x7D followed by the byte XOR 0x20; the byte marked end_of_frame is
// followed by the CRC-16/X.25 FCS (low byte first, escaped the same way) and the
// closing flag. invert_fcs (reset 1) selects the complemented FCS; write it through
// cfg_we/cfg_wdata only while the encoder is idle. A payload byte causes one line
// byte inside a frame if plain, two if escaped, one more for an opening flag, and
// three to five more for the frame end; while line_ch takes every byte, a plain
// stream sustains one payload byte per cycle. The front end computes the CRC for a
// byte in the cycle it is accepted and drops a command into a two-entry queue; the
// back end steps through that command one line byte per cycle, while line_ch is
// ready, into an output register, so the input keeps taking transactions while a
// line byte waits, until the queue is full.
module async_hdlc_frame_encoder (
	input  logic        clk,
	input  logic        arst_n,
	ahfe_in_if.sink     data_ch,
	ahfe_out_if.source  line_ch,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import ahfe_pkg::*;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	// Front end: CRC, frame state and the FCS choice are settled per payload byte.
	ahfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_ch  (data_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// The queue lets the front end run ahead while the back end expands a frame end.
	ahfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head_cmd(head_cmd)
	);

	// Back end: one line byte per cycle while line_ch is ready, popping a command with its last byte.
	ahfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head_cmd(head_cmd),
		.pop     (pop),
		.line_ch (line_ch)
	);

endmodule

### rtl/ahfe_front.sv
// Front end: accepts payload bytes, runs the CRC and frame state, builds commands.
module ahfe_front (
	input  logic            clk,
	input  logic            arst_n,
	ahfe_in_if.sink         data_ch,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	input  logic            q_full,
	output logic            push,
	output ahfe_pkg::cmd_t  push_cmd
);
	import ahfe_pkg::*;

	logic             invert_fcs_q;
	logic             inside_q;
	logic [CRC_W-1:0] crc_q;
	logic [CRC_W-1:0] crc_next;

	assign data_ch.ready = !q_full;
	assign push          = data_ch.valid && !q_full;
	assign crc_next      = crc_update(crc_q, data_ch.data_byte);

	always_comb begin
		push_cmd.open = !inside_q;
		push_cmd.data = data_ch.data_byte;
		push_cmd.eof  = data_ch.end_of_frame;
		push_cmd.fcs  = invert_fcs_q ? ~crc_next : crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_fcs_q <= 1'b1;
			inside_q     <= 1'b0;
			crc_q        <= CRC_INIT;
		end else begin
			if (cfg_we) begin
				invert_fcs_q <= cfg_wdata;
			end
			if (push) begin
				if (data_ch.end_of_frame) begin
					inside_q <= 1'b0;
					crc_q    <= CRC_INIT;
				end else begin
					inside_q <= 1'b1;
					crc_q    <= crc_next;
				end
			end
		end
	end

endmodule

### rtl/ahfe_queue.sv
// Short command queue between the front end and the back end.
module ahfe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ahfe_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output ahfe_pkg::cmd_t head_cmd
);
	import ahfe_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/ahfe_back.sv
// Back end: walks each command through the flag, data, FCS and flag phases it needs, with escaping.
module ahfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  ahfe_pkg::cmd_t head_cmd,
	output logic           pop,
	ahfe_out_if.source     line_ch
);
	import ahfe_pkg::*;

	typedef enum logic [4:0] {
		PH_OPEN   = 5'b00001,
		PH_DATA   = 5'b00010,
		PH_FCS_LO = 5'b00100,
		PH_FCS_HI = 5'b01000,
		PH_CLOSE  = 5'b10000
	} phase_t;

	phase_t            phase_q;
	phase_t            phase_eff;
	phase_t            phase_nxt;
	logic              esc_done_q;
	logic              load;
	logic              done;
	logic [BYTE_W-1:0] cur_byte;
	logic              escapable;
	logic              emit_esc;
	logic [BYTE_W-1:0] emit_byte;

	logic              valid_q;
	logic [BYTE_W-1:0] line_byte_q;
	logic              run_last_q;
	logic              frame_closed_q;

	assign load = !q_empty && (!valid_q || line_ch.ready);

	always_comb begin
		// A command that does not open a frame starts at its data byte.
		phase_eff = (phase_q == PH_OPEN && !head_cmd.open) ? PH_DATA : phase_q;
		case (phase_eff)
			PH_OPEN:   cur_byte = FLAG_BYTE;
			PH_DATA:   cur_byte = head_cmd.data;
			PH_FCS_LO: cur_byte = head_cmd.fcs[BYTE_W-1:0];
			PH_FCS_HI: cur_byte = head_cmd.fcs[CRC_W-1:BYTE_W];
			PH_CLOSE:  cur_byte = FLAG_BYTE;
			default:   cur_byte = FLAG_BYTE;
		endcase
		escapable = (phase_eff == PH_DATA || phase_eff == PH_FCS_LO ||
			phase_eff == PH_FCS_HI) && needs_escape(cur_byte);
		emit_esc  = escapable && !esc_done_q;
		emit_byte = emit_esc ? ESC_BYTE : (esc_done_q ? (cur_byte ^ ESC_XOR) : cur_byte);
		done      = 1'b0;
		phase_nxt = phase_eff;
		case (phase_eff)
			PH_OPEN:   phase_nxt = PH_DATA;
			PH_DATA: begin
				if (head_cmd.eof) begin
					phase_nxt = PH_FCS_LO;
				end else begin
					phase_nxt = PH_OPEN;
					done      = 1'b1;
				end
			end
			PH_FCS_LO: phase_nxt = PH_FCS_HI;
			PH_FCS_HI: phase_nxt = PH_CLOSE;
			PH_CLOSE: begin
				phase_nxt = PH_OPEN;
				done      = 1'b1;
			end
			default:   phase_nxt = PH_OPEN;
		endcase
		if (emit_esc) begin
			phase_nxt = phase_eff;
			done      = 1'b0;
		end
	end

	assign pop = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPEN;
			esc_done_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (load) begin
				phase_q    <= phase_nxt;
				esc_done_q <= emit_esc;
				valid_q    <= 1'b1;
			end else if (line_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_byte_q    <= emit_byte;
			run_last_q     <= done;
			frame_closed_q <= (phase_eff == PH_CLOSE);
		end
	end

	assign line_ch.valid        = valid_q;
	assign line_ch.line_byte    = line_byte_q;
	assign line_ch.run_last     = run_last_q;
	assign line_ch.frame_closed = frame_closed_q;

endmodule
